### rtl/core/icd_pkg.sv
// Shared types and constants for the serial clock divider search.
// Used by every module of the block; no dependencies.
package icd_pkg;
	localparam int HZW    = 31;
	localparam int SPW    = 20;
	localparam int NCODE  = 4;
	localparam int PSHIFT = 5;
	localparam int DOFF   = 3;
	localparam int DMAX   = 255;
	localparam int MW     = 9;
	localparam int HSW    = 28;
	localparam int FSTG   = HZW;
	localparam int BSTG   = SPW;
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic [HZW-1:0]            hz;
		logic [SPW-1:0]            speed;
		logic [NCODE-1:0]          ok;
		logic [NCODE-1:0][MW-1:0]  m;
	} mid_t;

	typedef struct packed {
		logic            found;
		logic [1:0]      code;
		logic [7:0]      div;
		logic [SPW-1:0]  short_amt;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;
endpackage

### rtl/core/i2c_clock_divider_search.sv
// Top level of the serial clock divider search.
// Depends on icd_pkg, icd_front, icd_queue, icd_back.
//
//  channel   handshake          beat
//  request   push / full        clock_hz, target_speed
//  result    pop / empty        found, predivider_code, divider_value, shortfall
//  config    cfg_valid / ready  cfg_data (filter_enable)
//
// One request per cycle sustained while neither part stalls. An accepted push
// passes the 31-step ceiling divider in the front, the middle queue, the 20-step
// achieved-speed dividers in the back and the result queue on its way to the
// outputs. Each part stalls only when its last stage holds a beat and the queue
// after it is full. Reset empties both queues and clears filter_enable.
module i2c_clock_divider_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [30:0] clock_hz,
	input  logic [19:0] target_speed,
	output logic        empty,
	input  logic        pop,
	output logic        found,
	output logic [1:0]  predivider_code,
	output logic [7:0]  divider_value,
	output logic [19:0] shortfall,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import icd_pkg::*;

	logic    fen_q;
	logic    wr;
	logic    rd;
	mid_t    wdata;
	mid_t    rdata;
	qstat_t  q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fen_q <= 1'b0;
		end else if (cfg_valid) begin
			fen_q <= cfg_data;
		end
	end

	icd_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.clock_hz(clock_hz), .target_speed(target_speed),
		.filter_enable(fen_q), .q_stat(q_stat), .wr(wr), .wdata(wdata)
	);

	icd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(wr), .wdata(wdata),
		.rd(rd), .rdata(rdata), .stat(q_stat)
	);

	icd_back u_back (
		.clk(clk), .arst_n(arst_n), .filter_enable(fen_q), .q_stat(q_stat),
		.q_rdata(rdata), .rd(rd), .empty(empty), .pop(pop), .found(found),
		.predivider_code(predivider_code), .divider_value(divider_value),
		.shortfall(shortfall)
	);

	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !found) |-> (predivider_code == 2'd0 && divider_value == 8'd0))
		else $error("not-found result carries nonzero code or divider");

	a_q_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("middle queue both full and empty");

	a_q_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(wr |-> !q_stat.full) and (rd |-> !q_stat.empty))
		else $error("middle queue overrun or underrun");
endmodule

### rtl/core/icd_front.sv
// Front part: takes requests, runs the pipelined ceiling division of the
// clock by the target, classifies the four predivider candidates.
// Depends on icd_pkg.
module icd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [30:0]         clock_hz,
	input  logic [19:0]         target_speed,
	input  logic                filter_enable,
	input  icd_pkg::qstat_t     q_stat,
	output logic                wr,
	output icd_pkg::mid_t       wdata
);
	import icd_pkg::*;

	logic              valid_s [0:FSTG];
	logic [HZW-1:0]    hz_s    [0:FSTG];
	logic [SPW-1:0]    sp_s    [0:FSTG];
	logic [SPW-1:0]    rem_s   [0:FSTG];
	logic [HZW-1:0]    nq_s    [0:FSTG];
	logic [SPW-1:0]    rem_n   [1:FSTG];
	logic [HZW-1:0]    nq_n    [1:FSTG];
	logic              fe;

	assign fe   = !valid_s[FSTG] || !q_stat.full;
	assign full = !fe;
	assign wr   = valid_s[FSTG] && !q_stat.full;

	always_comb begin
		logic [SPW:0] t;
		logic         ge;
		for (int k = 1; k <= FSTG; k++) begin
			t  = {rem_s[k-1], nq_s[k-1][HZW-1]};
			ge = t >= {1'b0, sp_s[k-1]};
			rem_n[k] = ge ? SPW'(t - {1'b0, sp_s[k-1]}) : t[SPW-1:0];
			nq_n[k]  = {nq_s[k-1][HZW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= FSTG; k++) valid_s[k] <= 1'b0;
		end else if (fe) begin
			valid_s[0] <= push;
			for (int k = 1; k <= FSTG; k++) valid_s[k] <= valid_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (fe) begin
			hz_s[0]  <= clock_hz;
			sp_s[0]  <= target_speed;
			rem_s[0] <= '0;
			nq_s[0]  <= clock_hz;
			for (int k = 1; k <= FSTG; k++) begin
				hz_s[k]  <= hz_s[k-1];
				sp_s[k]  <= sp_s[k-1];
				rem_s[k] <= rem_n[k];
				nq_s[k]  <= nq_n[k];
			end
		end
	end

	always_comb begin
		logic [31:0] q;
		logic [31:0] tot;
		logic [31:0] mf;
		logic [31:0] off;
		q   = {1'b0, nq_s[FSTG]} + {31'd0, rem_s[FSTG] != '0};
		off = 32'(DOFF) + {30'd0, filter_enable, 1'b0};
		wdata.hz    = hz_s[FSTG];
		wdata.speed = sp_s[FSTG];
		for (int c = 0; c < NCODE; c++) begin
			tot = (q + 32'((1 << (PSHIFT - c)) - 1)) >> (PSHIFT - c);
			mf  = (tot + 32'd1) >> 1;
			wdata.ok[c] = (sp_s[FSTG] != '0) && (mf >= off) && (mf <= off + 32'(DMAX));
			wdata.m[c]  = mf[MW-1:0];
		end
	end
endmodule

### rtl/core/icd_queue.sv
// Short queue between the front and back parts.
// Depends on icd_pkg.
module icd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  icd_pkg::mid_t    wdata,
	input  logic             rd,
	output icd_pkg::mid_t    rdata,
	output icd_pkg::qstat_t  stat
);
	import icd_pkg::*;

	mid_t            mem_q [QDEPTH];
	logic [QAW-1:0]  wp_q;
	logic [QAW-1:0]  rp_q;
	logic [QAW:0]    cnt_q;

	assign stat.full  = cnt_q == (QAW+1)'(QDEPTH);
	assign stat.empty = cnt_q == '0;
	assign rdata      = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(wr) - (QAW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end
endmodule

### rtl/core/icd_back.sv
// Back part: pipelined achieved-speed division for four candidates, best pick,
// and the result queue. Depends on icd_pkg.
module icd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                filter_enable,
	input  icd_pkg::qstat_t     q_stat,
	input  icd_pkg::mid_t       q_rdata,
	output logic                rd,
	output logic                empty,
	input  logic                pop,
	output logic                found,
	output logic [1:0]          predivider_code,
	output logic [7:0]          divider_value,
	output logic [19:0]         shortfall
);
	import icd_pkg::*;

	logic                        valid_s [0:BSTG];
	logic [SPW-1:0]              sp_s    [0:BSTG];
	logic [NCODE-1:0]            ok_s    [0:BSTG];
	logic [NCODE-1:0][MW-1:0]    m_s     [0:BSTG];
	logic [NCODE-1:0][MW-1:0]    rem_s   [0:BSTG];
	logic [NCODE-1:0][SPW-1:0]   nq_s    [0:BSTG];
	logic [NCODE-1:0][MW-1:0]    rem_n   [1:BSTG];
	logic [NCODE-1:0][SPW-1:0]   nq_n    [1:BSTG];
	logic [NCODE-1:0][MW-1:0]    rem_0;
	logic [NCODE-1:0][SPW-1:0]   nq_0;
	logic                        be;
	logic                        ow;
	res_t                        res;
	res_t                        oq_q [QDEPTH];
	logic [QAW-1:0]              owp_q;
	logic [QAW-1:0]              orp_q;
	logic [QAW:0]                ocnt_q;
	logic                        oq_full;
	logic                        ord;

	assign oq_full = ocnt_q == (QAW+1)'(QDEPTH);
	assign be      = !valid_s[BSTG] || !oq_full;
	assign rd      = be && !q_stat.empty;
	assign ow      = valid_s[BSTG] && !oq_full;
	assign empty   = ocnt_q == '0;
	assign ord     = pop && !empty;

	always_comb begin
		logic [HSW-1:0] hs;
		for (int c = 0; c < NCODE; c++) begin
			hs       = HSW'(q_rdata.hz >> (PSHIFT + 1 - c));
			rem_0[c] = {1'b0, hs[HSW-1:SPW]};
			nq_0[c]  = hs[SPW-1:0];
		end
	end

	always_comb begin
		logic [MW:0] t;
		logic        ge;
		for (int k = 1; k <= BSTG; k++) begin
			for (int c = 0; c < NCODE; c++) begin
				t  = {rem_s[k-1][c], nq_s[k-1][c][SPW-1]};
				ge = t >= {1'b0, m_s[k-1][c]};
				rem_n[k][c] = ge ? MW'(t - {1'b0, m_s[k-1][c]}) : t[MW-1:0];
				nq_n[k][c]  = {nq_s[k-1][c][SPW-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= BSTG; k++) valid_s[k] <= 1'b0;
		end else if (be) begin
			valid_s[0] <= rd;
			for (int k = 1; k <= BSTG; k++) valid_s[k] <= valid_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (be) begin
			sp_s[0]  <= q_rdata.speed;
			ok_s[0]  <= q_rdata.ok;
			m_s[0]   <= q_rdata.m;
			rem_s[0] <= rem_0;
			nq_s[0]  <= nq_0;
			for (int k = 1; k <= BSTG; k++) begin
				sp_s[k]  <= sp_s[k-1];
				ok_s[k]  <= ok_s[k-1];
				m_s[k]   <= m_s[k-1];
				rem_s[k] <= rem_n[k];
				nq_s[k]  <= nq_n[k];
			end
		end
	end

	always_comb begin
		logic [SPW-1:0] d;
		logic [MW-1:0]  off;
		off = MW'(DOFF) + {{(MW-2){1'b0}}, filter_enable, 1'b0};
		res.found     = 1'b0;
		res.code      = '0;
		res.div       = '0;
		res.short_amt = sp_s[BSTG];
		for (int c = 0; c < NCODE; c++) begin
			d = sp_s[BSTG] - nq_s[BSTG][c];
			if (ok_s[BSTG][c] && d < res.short_amt) begin
				res.found     = 1'b1;
				res.code      = 2'(c);
				res.div       = 8'(m_s[BSTG][c] - off);
				res.short_amt = d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (ow) owp_q <= owp_q + 1'b1;
			if (ord) orp_q <= orp_q + 1'b1;
			ocnt_q <= ocnt_q + (QAW+1)'(ow) - (QAW+1)'(ord);
		end
	end

	always_ff @(posedge clk) begin
		if (ow) oq_q[owp_q] <= res;
	end

	assign found           = oq_q[orp_q].found;
	assign predivider_code = oq_q[orp_q].code;
	assign divider_value   = oq_q[orp_q].div;
	assign shortfall       = oq_q[orp_q].short_amt;
endmodule
